>>> rtl/mle_pkg.sv
`timescale 1ns / 1ps
package mle_pkg;

  // Payload widths fixed by the channel format
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned DEP_W     = 16;
  localparam int unsigned MASK_W    = 27;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 27;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  // Nine store banks: plane mod 3 by row mod 3
  localparam int unsigned NBANK  = 9;
  localparam int unsigned QDEPTH = 4;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME_WIDTH     = 3'd0,
    CFG_VOLUME_HEIGHT    = 3'd1,
    CFG_VOLUME_DEPTH     = 3'd2,
    CFG_FOREGROUND_VALUE = 3'd3,
    CFG_BACKGROUND_VALUE = 3'd4,
    CFG_NEIGHBOR_MASK    = 3'd5
  } cfg_idx_t;

  localparam logic [DIM_W-1:0]  RST_VOLUME_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RST_VOLUME_HEIGHT = 9'd256;
  localparam logic [DEP_W-1:0]  RST_VOLUME_DEPTH  = 16'd1;
  localparam logic [PIX_W-1:0]  RST_FOREGROUND    = 16'd1;
  localparam logic [PIX_W-1:0]  RST_BACKGROUND    = 16'd0;
  localparam logic [MASK_W-1:0] RST_NEIGHBOR_MASK = 27'd95232;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_value;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic             end_of_volume;
  } out_t;

  // Per-output control travelling from front to back
  typedef struct packed {
    logic       last;
    logic       xl;
    logic       xr;
    logic       yl;
    logic       yr;
    logic       zl;
    logic       zr;
    logic [1:0] zm;
    logic [1:0] ym;
  } tok_t;

  // Residue arithmetic on values 0..2
  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  function automatic logic [1:0] mod3_sub(input logic [1:0] a, input logic [1:0] b);
    return (a >= b) ? 2'(a - b) : 2'(a + 2'd3 - b);
  endfunction

endpackage

>>> rtl/mle_store.sv
`timescale 1ns / 1ps
module mle_store
  import mle_pkg::*;
#(
  parameter int unsigned PW = DEF_PIXEL_BITS,
  parameter int unsigned AW = 8,
  parameter int unsigned BDEPTH = 256
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [1:0]                    wz,
  input  logic [1:0]                    wy,
  input  logic [AW-1:0]                 waddr,
  input  logic [PW-1:0]                 wdata,
  input  logic [NBANK-1:0][AW-1:0]      raddr_a,
  input  logic [NBANK-1:0][AW-1:0]      raddr_b,
  output logic [NBANK-1:0][PW-1:0]      rdata_a,
  output logic [NBANK-1:0][PW-1:0]      rdata_b
);

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    localparam logic [1:0] PZ = 2'(g / 3);
    localparam logic [1:0] PY = 2'(g % 3);
    logic [PW-1:0] mem [BDEPTH];
    logic          hit_w;

    assign hit_w = we && (wz == PZ) && (wy == PY);

    // Write one row entry; read two columns with write bypass
    always_ff @(posedge clk) begin
      if (hit_w) begin
        mem[waddr] <= wdata;
      end
      rdata_a[g] <= (hit_w && (waddr == raddr_a[g])) ? wdata : mem[raddr_a[g]];
      rdata_b[g] <= (hit_w && (waddr == raddr_b[g])) ? wdata : mem[raddr_b[g]];
    end
  end

endmodule

>>> rtl/mle_front.sv
`timescale 1ns / 1ps
module mle_front
  import mle_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int unsigned XW = $clog2(MAX_WIDTH),
  parameter int unsigned QW = 7,
  parameter int unsigned AW = QW + XW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  in_t                      in_data,
  input  logic [DIM_W-1:0]         cfg_w,
  input  logic [DIM_W-1:0]         cfg_h,
  input  logic [DEP_W-1:0]         cfg_d,
  output logic                     we,
  output logic [1:0]               wz,
  output logic [1:0]               wy,
  output logic [AW-1:0]            waddr,
  output logic [PIXEL_BITS-1:0]    wdata,
  output logic [NBANK-1:0][AW-1:0] raddr_a,
  output logic [NBANK-1:0][AW-1:0] raddr_b,
  output logic                     tok_v_r,
  output tok_t                     tok_r
);

  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [DEP_W-1:0] d_eff;

  // Arrival and emit positions, rows and planes also kept as div/mod 3
  logic [XW-1:0]    ix_r, ix_nxt, ex_r, ex_nxt;
  logic [YW-1:0]    iy_r, iy_nxt, ey_r, ey_nxt;
  logic [QW-1:0]    iyq_r, iyq_nxt, eyq_r, eyq_nxt;
  logic [1:0]       iym_r, iym_nxt, eym_r, eym_nxt;
  logic [DEP_W-1:0] iz_r, iz_nxt, ez_r, ez_nxt;
  logic [1:0]       izm_r, izm_nxt, ezm_r, ezm_nxt;

  logic [XW-1:0]    ix_a, ex_a;
  logic [YW-1:0]    iy_a, ey_a;
  logic [QW-1:0]    iyq_a, eyq_a;
  logic [1:0]       iym_a, eym_a, izm_a, ezm_a;
  logic [DEP_W-1:0] iz_a, ez_a;
  logic             e_last;

  logic             in_done;
  logic [XW-1:0]    nx;
  logic [YW-1:0]    ny;
  logic [DEP_W-1:0] nz;
  logic             ready;
  logic             emit;
  tok_t             tok_nxt;

  // Clamp the volume size to what the store holds
  always_comb begin
    if (cfg_w == '0) w_eff = WW'(1);
    else if (32'(cfg_w) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w);
    if (cfg_h == '0) h_eff = HW'(1);
    else if (32'(cfg_h) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h);
    d_eff = (cfg_d == '0) ? DEP_W'(1) : cfg_d;
  end

  assign in_done = (iz_r >= d_eff);
  assign we      = acc && (in_data.kind == KIND_PIXEL) && !in_done;
  assign wz      = izm_r;
  assign wy      = iym_r;
  assign waddr   = {iyq_r, ix_r};
  assign wdata   = PIXEL_BITS'(in_data.pixel_value);

  // Step the arrival position
  always_comb begin
    ix_a = ix_r; iy_a = iy_r; iyq_a = iyq_r; iym_a = iym_r; iz_a = iz_r; izm_a = izm_r;
    if (32'(ix_r) + 1 < 32'(w_eff)) begin
      ix_a = ix_r + 1'b1;
    end else begin
      ix_a = '0;
      if (32'(iy_r) + 1 < 32'(h_eff)) begin
        iy_a  = iy_r + 1'b1;
        iym_a = mod3_add(iym_r, 2'd1);
        iyq_a = (iym_r == 2'd2) ? iyq_r + 1'b1 : iyq_r;
      end else begin
        iy_a  = '0;
        iym_a = '0;
        iyq_a = '0;
        iz_a  = iz_r + 1'b1;
        izm_a = mod3_add(izm_r, 2'd1);
      end
    end
  end

  // Step the emit position; passing the last plane ends the volume
  always_comb begin
    ex_a = ex_r; ey_a = ey_r; eyq_a = eyq_r; eym_a = eym_r; ez_a = ez_r; ezm_a = ezm_r;
    e_last = 1'b0;
    if (32'(ex_r) + 1 < 32'(w_eff)) begin
      ex_a = ex_r + 1'b1;
    end else begin
      ex_a = '0;
      if (32'(ey_r) + 1 < 32'(h_eff)) begin
        ey_a  = ey_r + 1'b1;
        eym_a = mod3_add(eym_r, 2'd1);
        eyq_a = (eym_r == 2'd2) ? eyq_r + 1'b1 : eyq_r;
      end else begin
        ey_a   = '0;
        eym_a  = '0;
        eyq_a  = '0;
        ez_a   = ez_r + 1'b1;
        ezm_a  = mod3_add(ezm_r, 2'd1);
        e_last = (32'(ez_r) + 1 >= 32'(d_eff));
      end
    end
  end

  // Arrival position after this beat's write
  always_comb begin
    ix_nxt = ix_r; iy_nxt = iy_r; iyq_nxt = iyq_r; iym_nxt = iym_r;
    iz_nxt = iz_r; izm_nxt = izm_r;
    if (we) begin
      ix_nxt = ix_a; iy_nxt = iy_a; iyq_nxt = iyq_a; iym_nxt = iym_a;
      iz_nxt = iz_a; izm_nxt = izm_a;
    end
  end

  // Window corner, clipped to the volume
  always_comb begin
    nx = (32'(ex_r) + 1 < 32'(w_eff)) ? ex_r + 1'b1 : XW'(w_eff - 1'b1);
    ny = (32'(ey_r) + 1 < 32'(h_eff)) ? ey_r + 1'b1 : YW'(h_eff - 1'b1);
    nz = (32'(ez_r) + 1 < 32'(d_eff)) ? ez_r + 1'b1 : d_eff - 1'b1;
  end

  always_comb begin
    if (iz_nxt >= d_eff) ready = 1'b1;
    else if (iz_nxt != nz) ready = (iz_nxt > nz);
    else if (iy_nxt != ny) ready = (iy_nxt > ny);
    else ready = (ix_nxt > nx);
  end

  assign emit = acc && ready;

  // Read columns x and x+1 of the nine window rows, one row per bank
  always_comb begin
    logic [1:0]    dyi;
    logic [QW-1:0] q;
    for (int p = 0; p < NBANK; p++) begin
      dyi = mod3_add(mod3_sub(2'(p % 3), eym_r), 2'd1);
      case (dyi)
        2'd0:    q = (eym_r == 2'd0) ? ((eyq_r == '0) ? '0 : eyq_r - 1'b1) : eyq_r;
        2'd2:    q = (eym_r == 2'd2) ? eyq_r + 1'b1 : eyq_r;
        default: q = eyq_r;
      endcase
      raddr_a[p] = {q, ex_r};
      raddr_b[p] = {q, ex_r + 1'b1};
    end
  end

  always_comb begin
    tok_nxt.last = e_last;
    tok_nxt.xl   = (ex_r != '0);
    tok_nxt.xr   = (32'(ex_r) + 1 < 32'(w_eff));
    tok_nxt.yl   = (ey_r != '0);
    tok_nxt.yr   = (32'(ey_r) + 1 < 32'(h_eff));
    tok_nxt.zl   = (ez_r != '0);
    tok_nxt.zr   = (32'(ez_r) + 1 < 32'(d_eff));
    tok_nxt.zm   = ezm_r;
    tok_nxt.ym   = eym_r;
  end

  always_comb begin
    ex_nxt = ex_r; ey_nxt = ey_r; eyq_nxt = eyq_r; eym_nxt = eym_r;
    ez_nxt = ez_r; ezm_nxt = ezm_r;
    if (emit) begin
      ex_nxt = ex_a; ey_nxt = ey_a; eyq_nxt = eyq_a; eym_nxt = eym_a;
      ez_nxt = ez_a; ezm_nxt = ezm_a;
    end
  end

  // Hold positions; clear both at the end of a volume
  always_ff @(posedge clk) begin
    if (!rst_n || (emit && e_last)) begin
      ix_r <= '0; iy_r <= '0; iyq_r <= '0; iym_r <= '0; iz_r <= '0; izm_r <= '0;
      ex_r <= '0; ey_r <= '0; eyq_r <= '0; eym_r <= '0; ez_r <= '0; ezm_r <= '0;
    end else begin
      ix_r <= ix_nxt; iy_r <= iy_nxt; iyq_r <= iyq_nxt; iym_r <= iym_nxt;
      iz_r <= iz_nxt; izm_r <= izm_nxt;
      ex_r <= ex_nxt; ey_r <= ey_nxt; eyq_r <= eyq_nxt; eym_r <= eym_nxt;
      ez_r <= ez_nxt; ezm_r <= ezm_nxt;
    end
  end

  // Token lines up with the registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= emit;
    end
    tok_r <= tok_nxt;
  end

endmodule

>>> rtl/mle_queue.sv
`timescale 1ns / 1ps
module mle_queue
  import mle_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic                         nonempty,
  output logic [W-1:0]                 rdata,
  output logic [$clog2(QDEPTH+1)-1:0]  cnt_r
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  logic [W-1:0]     ent_r [QDEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;

  assign nonempty = (cnt_r != '0);
  assign rdata    = ent_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (32'(wp_r) == QDEPTH - 1) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (32'(rp_r) == QDEPTH - 1) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> 32'(cnt_r) < QDEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");
`endif

endmodule

>>> rtl/mle_back.sv
`timescale 1ns / 1ps
module mle_back
  import mle_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  tok_t                              q_tok,
  input  logic [NBANK-1:0][PIXEL_BITS-1:0]  q_col_a,
  input  logic [NBANK-1:0][PIXEL_BITS-1:0]  q_col_b,
  input  logic [PIX_W-1:0]                  fg_val,
  input  logic [PIX_W-1:0]                  bg_val,
  input  logic [MASK_W-1:0]                 nmask,
  output logic                              pop,
  input  logic                              out_ready,
  output logic                              out_valid,
  output out_t                              out_data
);

  localparam int unsigned PW = PIXEL_BITS;

  logic [2:0][2:0][PW-1:0] lft_r, cen, rgt;
  logic [PW-1:0]           fg, bg, res;
  logic                    hit;
  logic                    out_valid_r;
  out_t                    out_r;

  assign fg = PW'(fg_val);
  assign bg = PW'(bg_val);
  assign pop = q_valid && (!out_valid_r || out_ready);

  // Put bank data back into window order
  always_comb begin
    logic [1:0] pz, py;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        pz = mod3_sub(mod3_add(q_tok.zm, 2'(dz)), 2'd1);
        py = mod3_sub(mod3_add(q_tok.ym, 2'(dy)), 2'd1);
        cen[dz][dy] = q_col_a[32'(pz) * 3 + 32'(py)];
        rgt[dz][dy] = q_col_b[32'(pz) * 3 + 32'(py)];
      end
    end
  end

  // Look for an enabled background neighbour inside the volume
  always_comb begin
    logic          ok;
    logic [PW-1:0] nv;
    hit = 1'b0;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ok = nmask[dz * 9 + dy * 3 + dx];
          if (dx == 0) ok = ok && q_tok.xl;
          if (dx == 2) ok = ok && q_tok.xr;
          if (dy == 0) ok = ok && q_tok.yl;
          if (dy == 2) ok = ok && q_tok.yr;
          if (dz == 0) ok = ok && q_tok.zl;
          if (dz == 2) ok = ok && q_tok.zr;
          case (dx)
            0:       nv = lft_r[dz][dy];
            1:       nv = cen[dz][dy];
            default: nv = rgt[dz][dy];
          endcase
          if (ok && (nv == bg)) hit = 1'b1;
        end
      end
    end
    res = ((cen[1][1] == fg) && hit) ? bg : cen[1][1];
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.out_value     <= PIX_W'(res);
      out_r.end_of_volume <= q_tok.last;
      lft_r               <= cen;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/masked_label_erosion_3d.sv
`timescale 1ns / 1ps
// Masked 3x3x3 erosion of a labelled volume streamed in raster order.
// in_*  : one beat per item; kind 0 carries a pixel, kind 1 is a flush
//         tick that drains one pending output. A pixel past the end of
//         the volume is dropped but drains like a flush tick.
// out_* : eroded pixels in raster order; end_of_volume marks the last one,
//         after which a new volume starts at the origin.
// cfg_* : register writes (index, data); always ready. Write only while
//         no result is outstanding.
// Throughput: one item per cycle while in_ready is high. Each item reads
// two columns of nine store banks (three planes by three rows), so a
// pixel's whole window is fetched with one write and two reads per bank.
// A result reaches out_valid from the beat that makes it through the
// registered store read, a four-entry queue and the output register.
// Back-pressure: while out_ready is low the queue fills; in_ready drops
// when the queue and the read stage together hold four results.
// Reset: positions and registers return to defaults; the pixel store is
// not cleared and needs no clearing pass.
module masked_label_erosion_3d
  import mle_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned RB     = (MAX_HEIGHT + 3) / 3;
  localparam int unsigned QW     = $clog2(RB);
  localparam int unsigned AW     = QW + XW;
  localparam int unsigned BDEPTH = RB * (2 ** XW);
  localparam int unsigned QW_DAT = $bits(tok_t) + 2 * NBANK * PIXEL_BITS;

  logic [DIM_W-1:0]  vw_r, vh_r;
  logic [DEP_W-1:0]  vd_r;
  logic [PIX_W-1:0]  fg_r, bg_r;
  logic [MASK_W-1:0] nm_r;

  logic                                acc;
  logic                                we;
  logic [1:0]                          wz, wy;
  logic [AW-1:0]                       waddr;
  logic [PIXEL_BITS-1:0]               wdata;
  logic [NBANK-1:0][AW-1:0]            raddr_a, raddr_b;
  logic [NBANK-1:0][PIXEL_BITS-1:0]    rdata_a, rdata_b;
  logic                                tok_v;
  tok_t                                tok;
  logic                                pop, q_nonempty;
  logic [QW_DAT-1:0]                   q_rdata;
  logic [$clog2(QDEPTH+1)-1:0]         q_cnt;
  tok_t                                q_tok;
  logic [NBANK-1:0][PIXEL_BITS-1:0]    q_col_a, q_col_b;

  // Register file
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= RST_VOLUME_WIDTH;
      vh_r <= RST_VOLUME_HEIGHT;
      vd_r <= RST_VOLUME_DEPTH;
      fg_r <= RST_FOREGROUND;
      bg_r <= RST_BACKGROUND;
      nm_r <= RST_NEIGHBOR_MASK;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VOLUME_WIDTH:     vw_r <= cfg_data[DIM_W-1:0];
        CFG_VOLUME_HEIGHT:    vh_r <= cfg_data[DIM_W-1:0];
        CFG_VOLUME_DEPTH:     vd_r <= cfg_data[DEP_W-1:0];
        CFG_FOREGROUND_VALUE: fg_r <= cfg_data[PIX_W-1:0];
        CFG_BACKGROUND_VALUE: bg_r <= cfg_data[PIX_W-1:0];
        CFG_NEIGHBOR_MASK:    nm_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a beat only when the queue can hold its result
  assign in_ready = (32'(q_cnt) + 32'(tok_v)) < QDEPTH;
  assign acc      = in_valid && in_ready;

  mle_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS),
    .XW        (XW),
    .QW        (QW),
    .AW        (AW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .cfg_w   (vw_r),
    .cfg_h   (vh_r),
    .cfg_d   (vd_r),
    .we      (we),
    .wz      (wz),
    .wy      (wy),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .tok_v_r (tok_v),
    .tok_r   (tok)
  );

  mle_store #(
    .PW    (PIXEL_BITS),
    .AW    (AW),
    .BDEPTH(BDEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wz      (wz),
    .wy      (wy),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mle_queue #(
    .W(QW_DAT)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_v),
    .wdata    ({tok, rdata_a, rdata_b}),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata),
    .cnt_r    (q_cnt)
  );

  assign {q_tok, q_col_a, q_col_b} = q_rdata;

  mle_back #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_tok     (q_tok),
    .q_col_a   (q_col_a),
    .q_col_b   (q_col_b),
    .fg_val    (fg_r),
    .bg_val    (bg_r),
    .nmask     (nm_r),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
